FILE: rtl/core/cqar_pkg.sv
// ----------------------------------------------------------------------------
// cqar_pkg
// Shared codes, register indexes and control types of the command queue
// with acknowledge and retry.
// ----------------------------------------------------------------------------
package cqar_pkg;

  // request codes carried in s_tuser
  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_SVC  = 2'd1;
  localparam logic [1:0] REQ_RESP = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  // result kinds carried in m_tuser
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_BINARY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_DIMMER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_CURTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_THERMO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_RGB     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd7;

  // ACK byte positions per command type
  localparam logic [7:0] POS_BINARY  = 8'd3;
  localparam logic [7:0] POS_DIMMER  = 8'd3;
  localparam logic [7:0] POS_CURTAIN = 8'd3;
  localparam logic [7:0] POS_THERMO  = 8'd18;
  localparam logic [7:0] POS_RGB     = 8'd5;

  // register reset values
  localparam logic [7:0] ACK_CODE_RST     = 8'd6;
  localparam logic [7:0] TIMEOUT_RST      = 8'd10;
  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd4;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] timeout_ticks;
    logic [3:0] max_attempts;
  } cqar_cfg_t;

  typedef struct packed {
    logic slot_we;
    logic pay_we;
    logic slot_re;
    logic pay_re;
  } cqar_mem_ctl_t;

endpackage

FILE: rtl/core/cqar_cfg.sv
// ----------------------------------------------------------------------------
// cqar_cfg
// Configuration registers and the type to ACK position lookup.
// ----------------------------------------------------------------------------
module cqar_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [cqar_pkg::CFG_IDX_W-1:0] index,
  input  logic [7:0]                     data,
  input  logic [7:0]                     lookup_type,
  output logic                           lookup_hit,
  output logic [7:0]                     lookup_pos,
  output cqar_pkg::cqar_cfg_t            cfg
);

  logic [7:0] ack_code;
  logic [7:0] type_binary;
  logic [7:0] type_dimmer;
  logic [7:0] type_curtain;
  logic [7:0] type_thermo;
  logic [7:0] type_rgb;
  logic [7:0] timeout_ticks;
  logic [3:0] max_attempts;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_code      <= cqar_pkg::ACK_CODE_RST;
      type_binary   <= '0;
      type_dimmer   <= '0;
      type_curtain  <= '0;
      type_thermo   <= '0;
      type_rgb      <= '0;
      timeout_ticks <= cqar_pkg::TIMEOUT_RST;
      max_attempts  <= cqar_pkg::MAX_ATTEMPTS_RST;
    end else if (we) begin
      unique case (index)
        cqar_pkg::REG_ACK_CODE:     ack_code      <= data;
        cqar_pkg::REG_TYPE_BINARY:  type_binary   <= data;
        cqar_pkg::REG_TYPE_DIMMER:  type_dimmer   <= data;
        cqar_pkg::REG_TYPE_CURTAIN: type_curtain  <= data;
        cqar_pkg::REG_TYPE_THERMO:  type_thermo   <= data;
        cqar_pkg::REG_TYPE_RGB:     type_rgb      <= data;
        cqar_pkg::REG_TIMEOUT:      timeout_ticks <= data;
        cqar_pkg::REG_MAX_ATTEMPTS: max_attempts  <= data[3:0];
        default: ;
      endcase
    end
  end

  // first matching register wins
  always_comb begin
    lookup_hit = 1'b1;
    lookup_pos = '0;
    priority if (lookup_type == type_binary)  lookup_pos = cqar_pkg::POS_BINARY;
    else if (lookup_type == type_dimmer)      lookup_pos = cqar_pkg::POS_DIMMER;
    else if (lookup_type == type_curtain)     lookup_pos = cqar_pkg::POS_CURTAIN;
    else if (lookup_type == type_thermo)      lookup_pos = cqar_pkg::POS_THERMO;
    else if (lookup_type == type_rgb)         lookup_pos = cqar_pkg::POS_RGB;
    else                                      lookup_hit = 1'b0;
  end

  assign cfg.ack_code      = ack_code;
  assign cfg.timeout_ticks = timeout_ticks;
  assign cfg.max_attempts  = max_attempts;

endmodule

FILE: rtl/core/cqar_store.sv
// ----------------------------------------------------------------------------
// cqar_store
// Slot memories: type and length per slot, payload bytes per slot and
// index. Written at the tail slot, read at the head slot, registered read.
// ----------------------------------------------------------------------------
module cqar_store #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic                       clk,
  input  cqar_pkg::cqar_mem_ctl_t    ctl,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_slot,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_idx,
  input  logic [7:0]                 wr_type,
  input  logic [$clog2(MAX_PAYLOAD+1)-1:0] wr_len,
  input  logic [7:0]                 wr_byte,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_slot,
  input  logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_idx,
  output logic [7:0]                 rd_type,
  output logic [$clog2(MAX_PAYLOAD+1)-1:0] rd_len,
  output logic [7:0]                 rd_byte
);

  localparam int unsigned IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PAY_DEPTH = QUEUE_DEPTH << IDX_W;

  logic [7:0]       type_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0] len_mem  [QUEUE_DEPTH];
  logic [7:0]       pay_mem  [PAY_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.slot_we) begin
      type_mem[wr_slot] <= wr_type;
      len_mem[wr_slot]  <= wr_len;
    end
    if (ctl.slot_re) begin
      rd_type <= type_mem[rd_slot];
      rd_len  <= len_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay_we) begin
      pay_mem[{wr_slot, wr_idx}] <= wr_byte;
    end
    if (ctl.pay_re) begin
      rd_byte <= pay_mem[{rd_slot, rd_idx}];
    end
  end

endmodule

FILE: rtl/core/command_queue_ack_retry_unit.sv
// ----------------------------------------------------------------------------
// command_queue_ack_retry_unit
// Ring queue of bus commands with stop-and-wait send, ACK check and retry.
// ----------------------------------------------------------------------------
// The result of a last enqueue byte or a finishing tick appears on the
// output register the cycle after the item is accepted.
// A send (service or retry tick) reads the slot memory first: the type byte
// moves from the slot read register to the output register, then payload
// bytes follow from the payload memory, one per cycle unless output stalls.
// Reset clears pointers, counters and the send state; the slot memories are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module command_queue_ack_retry_unit #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cqar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] cmd_type, [15:8] data_byte, [16] data_present,
  // [24:17] resp_byte, [32:25] resp_index, [39:33] zero
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,   // data_last
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] tx_byte, [8] tx_is_type, [9] enq_accepted, [10] done_acked,
  // [15:11] zero
  output logic [15:0] m_tdata,
  output logic        m_tlast,   // tx_last
  output logic [1:0]  m_tuser    // [1:0] out_kind
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAY
  } state_t;

  state_t                  state;
  logic [PTR_W-1:0]        head_ptr;
  logic [PTR_W-1:0]        tail_ptr;
  logic [CNT_W-1:0]        entry_count;
  logic [LEN_W-1:0]        build_length;
  logic                    waiting;
  logic                    ack_seen;
  logic [3:0]              attempts_done;
  logic [7:0]              ticks_left;
  logic [7:0]              ack_position;
  logic                    send_first;
  logic [LEN_W-1:0]        send_len;
  logic [IDX_W-1:0]        send_idx;

  logic [1:0]              out_kind;
  logic [7:0]              tx_byte;
  logic                    tx_is_type;
  logic                    tx_last;
  logic                    enq_accepted;
  logic                    done_acked;

  // input fields
  logic [1:0]              req_type;
  logic [7:0]              cmd_type;
  logic [7:0]              data_byte;
  logic                    data_present;
  logic                    data_last;
  logic [7:0]              resp_byte;
  logic [7:0]              resp_index;

  cqar_pkg::cqar_cfg_t     cfg;
  cqar_pkg::cqar_mem_ctl_t mem_ctl;
  logic                    lookup_hit;
  logic [7:0]              lookup_pos;
  logic [7:0]              rd_type;
  logic [LEN_W-1:0]        rd_len;
  logic [7:0]              rd_byte;
  logic [IDX_W-1:0]        rd_idx;

  logic                    out_free;
  logic                    accept;
  logic                    queue_full;
  logic                    byte_count;
  logic                    commit;
  logic [LEN_W-1:0]        wr_len;
  logic                    service_go;
  logic                    tick_go;
  logic                    tick_expire;
  logic [3:0]              attempt_limit;
  logic                    retry_go;
  logic                    hdr_emit;
  logic                    pay_emit;
  logic                    pay_last;

  assign req_type     = s_tuser;
  assign cmd_type     = s_tdata[7:0];
  assign data_byte    = s_tdata[15:8];
  assign data_present = s_tdata[16];
  assign resp_byte    = s_tdata[24:17];
  assign resp_index   = s_tdata[32:25];
  assign data_last    = s_tlast;

  assign cfg_ready = 1'b1;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign accept     = s_tvalid && s_tready;
  assign queue_full = (entry_count == CNT_W'(QUEUE_DEPTH));

  assign byte_count = accept && (req_type == cqar_pkg::REQ_ENQ) && data_present &&
                      (build_length < LEN_W'(MAX_PAYLOAD));
  assign commit     = accept && (req_type == cqar_pkg::REQ_ENQ) && data_last;
  assign wr_len     = byte_count ? build_length + 1'b1 : build_length;

  assign service_go = accept && (req_type == cqar_pkg::REQ_SVC) && !waiting &&
                      (entry_count != '0);
  assign tick_go    = accept && (req_type == cqar_pkg::REQ_TICK) && waiting;
  // timeout of zero behaves as one: a single tick expires it
  assign tick_expire   = tick_go && !ack_seen && (ticks_left <= 8'd1);
  assign attempt_limit = (cfg.max_attempts == '0) ? 4'd1 : cfg.max_attempts;
  assign retry_go      = tick_expire && (attempts_done < attempt_limit);

  assign hdr_emit = (state == ST_HDR) && out_free;
  assign pay_emit = (state == ST_PAY) && out_free;
  assign pay_last = ((LEN_W'(send_idx) + 1'b1) == send_len);
  assign rd_idx   = (state == ST_HDR) ? '0 : send_idx + 1'b1;

  assign mem_ctl.slot_we = commit && !queue_full;
  assign mem_ctl.pay_we  = byte_count && !queue_full;
  assign mem_ctl.slot_re = service_go || retry_go;
  assign mem_ctl.pay_re  = (hdr_emit && (rd_len != '0)) || (pay_emit && !pay_last);

  cqar_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .we          (cfg_valid),
    .index       (cfg_index),
    .data        (cfg_data),
    .lookup_type (rd_type),
    .lookup_hit  (lookup_hit),
    .lookup_pos  (lookup_pos),
    .cfg         (cfg)
  );

  cqar_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_slot (tail_ptr),
    .wr_idx  (build_length[IDX_W-1:0]),
    .wr_type (cmd_type),
    .wr_len  (wr_len),
    .wr_byte (data_byte),
    .rd_slot (head_ptr),
    .rd_idx  (rd_idx),
    .rd_type (rd_type),
    .rd_len  (rd_len),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      entry_count   <= '0;
      build_length  <= '0;
      waiting       <= 1'b0;
      ack_seen      <= 1'b1;
      attempts_done <= '0;
      ticks_left    <= '0;
      ack_position  <= '0;
      send_first    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req_type)
              cqar_pkg::REQ_ENQ: begin
                if (commit) begin
                  build_length <= '0;
                  if (!queue_full) begin
                    tail_ptr    <= (tail_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : tail_ptr + 1'b1;
                    entry_count <= entry_count + 1'b1;
                  end
                  m_tvalid     <= 1'b1;
                  out_kind     <= cqar_pkg::KIND_STATUS;
                  tx_byte      <= '0;
                  tx_is_type   <= 1'b0;
                  tx_last      <= 1'b0;
                  enq_accepted <= !queue_full;
                  done_acked   <= 1'b0;
                end else if (byte_count) begin
                  build_length <= build_length + 1'b1;
                end
              end
              cqar_pkg::REQ_SVC: begin
                if (service_go) begin
                  waiting       <= 1'b1;
                  attempts_done <= 4'd1;
                  ticks_left    <= cfg.timeout_ticks;
                  ack_seen      <= 1'b0;
                  send_first    <= 1'b1;
                  state         <= ST_HDR;
                end
              end
              cqar_pkg::REQ_RESP: begin
                if (waiting && (resp_index == ack_position) &&
                    (resp_byte == cfg.ack_code)) begin
                  ack_seen <= 1'b1;
                end
              end
              cqar_pkg::REQ_TICK: begin
                if (tick_go) begin
                  if (!ack_seen && !tick_expire) begin
                    ticks_left <= ticks_left - 1'b1;
                  end else if (retry_go) begin
                    // resend the head command
                    attempts_done <= attempts_done + 1'b1;
                    ticks_left    <= cfg.timeout_ticks;
                    ack_seen      <= 1'b0;
                    send_first    <= 1'b0;
                    state         <= ST_HDR;
                  end else begin
                    // finish: acknowledged, or dropped after the last send
                    if (!ack_seen) ticks_left <= '0;
                    head_ptr    <= (head_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : head_ptr + 1'b1;
                    if (entry_count != '0) entry_count <= entry_count - 1'b1;
                    waiting      <= 1'b0;
                    ack_seen     <= 1'b0;
                    m_tvalid     <= 1'b1;
                    out_kind     <= cqar_pkg::KIND_DONE;
                    tx_byte      <= '0;
                    tx_is_type   <= 1'b0;
                    tx_last      <= 1'b0;
                    enq_accepted <= 1'b0;
                    done_acked   <= ack_seen;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        ST_HDR: begin
          if (hdr_emit) begin
            // an unknown type keeps the previous position
            if (send_first && lookup_hit) ack_position <= lookup_pos;
            send_len     <= rd_len;
            send_idx     <= '0;
            m_tvalid     <= 1'b1;
            out_kind     <= cqar_pkg::KIND_TX;
            tx_byte      <= rd_type;
            tx_is_type   <= 1'b1;
            tx_last      <= (rd_len == '0);
            enq_accepted <= 1'b0;
            done_acked   <= 1'b0;
            state        <= (rd_len == '0) ? ST_IDLE : ST_PAY;
          end
        end

        ST_PAY: begin
          if (pay_emit) begin
            m_tvalid     <= 1'b1;
            out_kind     <= cqar_pkg::KIND_TX;
            tx_byte      <= rd_byte;
            tx_is_type   <= 1'b0;
            tx_last      <= pay_last;
            enq_accepted <= 1'b0;
            done_acked   <= 1'b0;
            if (pay_last) begin
              state <= ST_IDLE;
            end else begin
              send_idx <= send_idx + 1'b1;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, done_acked, enq_accepted, tx_is_type, tx_byte};
  assign m_tlast = tx_last;
  assign m_tuser = out_kind;

endmodule
